FILE: sv/dtr_pkg.sv
`timescale 1ns / 1ps
// Package for the divider timer with reload: command codes, reset values,
// the state record and the divider-bit and counter-increment helpers. No dependencies.
package dtr_pkg;

	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_DIV_RESET  = 3'd1;
	localparam logic [2:0] CMD_WR_COUNTER = 3'd2;
	localparam logic [2:0] CMD_WR_RELOAD  = 3'd3;
	localparam logic [2:0] CMD_WR_CONTROL = 3'd4;

	localparam logic [15:0] DIV_RESET  = 16'h0018;
	localparam logic [7:0]  CTRL_RESET = 8'hF8;
	localparam int          ENABLE_BIT = 2;

	typedef struct packed {
		logic [1:0]  prescaler;
		logic [15:0] divider;
		logic [7:0]  counter;
		logic [7:0]  reload;
		logic [7:0]  control;
		logic        ovf_pending;
		logic        reload_window;
	} state_t;

	// Divider bit picked by the rate select field
	function automatic logic div_bit(input logic [15:0] d, input logic [7:0] ctl);
		logic b;
		case (ctl[1:0])
			2'd0: b = d[9];
			2'd1: b = d[3];
			2'd2: b = d[5];
			default: b = d[7];
		endcase
		return b;
	endfunction

	function automatic state_t bump(input state_t s);
		state_t r;
		r = s;
		if (s.counter == 8'hFF)
			r.ovf_pending = 1'b1;
		else
			r.counter = s.counter + 8'd1;
		return r;
	endfunction

endpackage

FILE: sv/dtr_step.sv
`timescale 1ns / 1ps
// Next-state logic for one command beat of the divider timer.
// Depends on dtr_pkg.
module dtr_step import dtr_pkg::*; (
	input  state_t     cur,
	input  logic [2:0] command,
	input  logic [7:0] write_data,
	output state_t     nxt,
	output logic       pulse
);

	logic [15:0] div_inc;
	logic        en_old;
	logic        en_new;

	assign div_inc = cur.divider + 16'd1;
	assign en_old  = cur.control[ENABLE_BIT];
	assign en_new  = write_data[ENABLE_BIT];

	always_comb begin
		state_t s;
		s = cur;
		pulse = 1'b0;
		case (command)
			CMD_TICK: begin
				if (cur.prescaler != 2'd3) begin
					s.prescaler = cur.prescaler + 2'd1;
				end else begin
					s.prescaler = 2'd0;
					s.divider = div_inc;
					if (cur.ovf_pending) begin
						s.ovf_pending = 1'b0;
						s.reload_window = 1'b1;
						s.counter = cur.reload;
						pulse = 1'b1;
					end else if (cur.reload_window) begin
						s.reload_window = 1'b0;
					end
					if (en_old && div_bit(cur.divider, cur.control) &&
					    !div_bit(div_inc, cur.control))
						s = bump(s);
				end
			end
			CMD_DIV_RESET: begin
				s.divider = 16'd0;
				if (en_old && div_bit(cur.divider, cur.control))
					s = bump(s);
			end
			CMD_WR_COUNTER: begin
				if (cur.ovf_pending) begin
					s.ovf_pending = 1'b0;
					s.counter = write_data;
				end else if (!cur.reload_window) begin
					s.counter = write_data;
				end
			end
			CMD_WR_RELOAD: begin
				if (cur.reload_window)
					s.counter = write_data;
				s.reload = write_data;
			end
			CMD_WR_CONTROL: begin
				s.control = write_data;
				if (en_old) begin
					if (!en_new) begin
						if (div_bit(cur.divider, cur.control))
							s = bump(s);
					end else if (write_data[1:0] != cur.control[1:0]) begin
						if (div_bit(cur.divider, cur.control) &&
						    !div_bit(cur.divider, write_data))
							s = bump(s);
					end
				end
			end
			default: begin
			end
		endcase
		nxt = s;
	end

endmodule

FILE: sv/divider_timer_with_reload.sv
`timescale 1ns / 1ps
// Divider timer with delayed reload: top level with input, state and result registers.
// Depends on dtr_pkg and dtr_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: tick, divider
//   reset, or a write of the counter, reload or control register (write_data).
//   Output channel (out_valid/out_ready) returns one beat per command with the
//   divider, counter, reload and control values after that command, plus
//   interrupt_pulse when a reload happened.
//   Pipeline: an accepted beat is registered at the input stage, and its result
//   is registered in the state/result registers when the output can take it.
//   Throughput: one beat per cycle while results are taken; the state update for a beat is a single
//   pass of logic between the input register and the state/result registers.
//   Reset: divider 0x0018, control 0xF8, all else zero, both channels empty.
//   Stall: while a result waits on out_ready, one more beat is held at the
//   input stage; in_ready then drops until the result is taken.
module divider_timer_with_reload import dtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] divider_value,
	output logic [7:0]  counter_value,
	output logic [7:0]  reload_value,
	output logic [7:0]  control_value,
	output logic        interrupt_pulse
);

	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] data_s1;
	logic       advance;
	state_t     st_q;
	state_t     st_nxt;
	logic       pulse_nxt;
	logic       out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			data_s1    <= write_data;
		end
	end

	dtr_step u_step (
		.cur        (st_q),
		.command    (command_s1),
		.write_data (data_s1),
		.nxt        (st_nxt),
		.pulse      (pulse_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.prescaler     <= 2'd0;
			st_q.divider       <= DIV_RESET;
			st_q.counter       <= 8'd0;
			st_q.reload        <= 8'd0;
			st_q.control       <= CTRL_RESET;
			st_q.ovf_pending   <= 1'b0;
			st_q.reload_window <= 1'b0;
			out_valid_q        <= 1'b0;
		end else begin
			if (advance) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			divider_value   <= st_nxt.divider;
			counter_value   <= st_nxt.counter;
			reload_value    <= st_nxt.reload;
			control_value   <= st_nxt.control;
			interrupt_pulse <= pulse_nxt;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_pulse_opens_window: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pulse_nxt |=> st_q.reload_window)
		else $error("reload did not open the reload window");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("timer state changed without a beat");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed beat produced no result");
`endif

endmodule
